// ===== design/lwbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lwbh_pkg
// Shared types and constants for the line walk box hit block.
// ----------------------------------------------------------------------------
package lwbh_pkg;

    localparam int COORD_W   = 16;
    localparam int HALF_W    = 15;
    localparam int STEP_W    = 10;
    localparam int MAG_W     = COORD_W + 1;
    localparam int PT_W      = COORD_W + 1;
    localparam int OFS_W     = PT_W + 1;
    localparam int PEN_W     = OFS_W + 1;
    localparam int ERR_W     = MAG_W + 2;
    localparam int CONTACT_W = 17;
    localparam int PEN_OUT_W = 16;

    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(1023);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [MAG_W-1:0]          adx;
        logic [MAG_W-1:0]          ady;
        logic                      sx_neg;
        logic                      sy_neg;
        logic                      xmajor;
        logic [STEP_W-1:0]         steps;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [HALF_W-1:0]         hx;
        logic [HALF_W-1:0]         hy;
    } item_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

endpackage

// ===== design/lwbh_front.sv =====
// ----------------------------------------------------------------------------
// lwbh_front
// Accepts a transaction, classifies the ray (step signs, magnitudes, major
// axis, clamped step count) and holds it in a two-entry queue for the walker.
// ----------------------------------------------------------------------------
module lwbh_front #(
    parameter logic [lwbh_pkg::STEP_W-1:0] MAX_STEPS = lwbh_pkg::MAX_STEPS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [lwbh_pkg::COORD_W-1:0] ray_x,
    input  logic signed [lwbh_pkg::COORD_W-1:0] ray_y,
    input  logic signed [lwbh_pkg::COORD_W-1:0] dir_x,
    input  logic signed [lwbh_pkg::COORD_W-1:0] dir_y,
    input  logic [lwbh_pkg::STEP_W-1:0]        steps,
    input  logic signed [lwbh_pkg::COORD_W-1:0] box_cx,
    input  logic signed [lwbh_pkg::COORD_W-1:0] box_cy,
    input  logic [lwbh_pkg::HALF_W-1:0]        box_hx,
    input  logic [lwbh_pkg::HALF_W-1:0]        box_hy,
    output lwbh_pkg::item_t                    head,
    input  lwbh_pkg::q_ctrl_t                  ctrl_in,
    output lwbh_pkg::q_ctrl_t                  ctrl_out
);
    import lwbh_pkg::*;

    item_t              cls;
    logic signed [MAG_W-1:0] dx_ext;
    logic signed [MAG_W-1:0] dy_ext;
    logic               push;
    item_t              q_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    always_comb
    begin
        dx_ext     = MAG_W'(dir_x);
        dy_ext     = MAG_W'(dir_y);
        cls.x      = ray_x;
        cls.y      = ray_y;
        cls.sx_neg = dir_x[COORD_W-1];
        cls.sy_neg = dir_y[COORD_W-1];
        cls.adx    = dir_x[COORD_W-1] ? MAG_W'(-dx_ext) : MAG_W'(dx_ext);
        cls.ady    = dir_y[COORD_W-1] ? MAG_W'(-dy_ext) : MAG_W'(dy_ext);
        cls.xmajor = (cls.ady <= cls.adx);
        cls.steps  = (steps > MAX_STEPS) ? MAX_STEPS : steps;
        cls.cx     = box_cx;
        cls.cy     = box_cy;
        cls.hx     = box_hx;
        cls.hy     = box_hy;
    end

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = ctrl_in.pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(ctrl_in.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    assign head           = q_reg[rd_ptr_reg];
    assign ctrl_out.valid = (count_reg != 2'd0);
    assign ctrl_out.pop   = ctrl_in.pop;

endmodule

// ===== design/lwbh_walk.sv =====
// ----------------------------------------------------------------------------
// lwbh_walk
// Walks the ray one Bresenham point per cycle, tests each point against the
// box and issues one result per transaction.
// ----------------------------------------------------------------------------
module lwbh_walk (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lwbh_pkg::item_t                       head,
    input  lwbh_pkg::q_ctrl_t                     q_stat,
    output lwbh_pkg::q_ctrl_t                     q_cmd,
    output logic                                  done,
    output logic                                  is_hit,
    output logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_x,
    output logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_y,
    output logic signed [lwbh_pkg::CONTACT_W-1:0] contact_x,
    output logic signed [lwbh_pkg::CONTACT_W-1:0] contact_y
);
    import lwbh_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                   state_reg, state_next;
    logic signed [PT_W-1:0]   x_reg, x_next;
    logic signed [PT_W-1:0]   y_reg, y_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  inc_a_reg, inc_a_next;
    logic signed [ERR_W-1:0]  inc_b_reg, inc_b_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic                     xmaj_reg, xmaj_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic [HALF_W-1:0]        hx_reg, hx_next;
    logic [HALF_W-1:0]        hy_reg, hy_next;
    logic                     done_reg, done_next;
    logic                     hit_reg, hit_next;
    logic signed [PEN_OUT_W-1:0] pen_x_reg, pen_x_next;
    logic signed [PEN_OUT_W-1:0] pen_y_reg, pen_y_next;
    logic signed [CONTACT_W-1:0] con_x_reg, con_x_next;
    logic signed [CONTACT_W-1:0] con_y_reg, con_y_next;

    logic                     pop;
    logic [MAG_W-1:0]         major;
    logic [MAG_W-1:0]         minor;
    logic signed [OFS_W-1:0]  ox, oy;
    logic [OFS_W-1:0]         aox, aoy;
    logic signed [PEN_W-1:0]  px, py;
    logic signed [PEN_W-1:0]  px_s, py_s;
    logic                     hit;
    logic                     pick_x;
    logic signed [ERR_W-1:0]  err_a, err_b;
    logic                     minor_go;
    logic signed [PT_W-1:0]   x_step, y_step;
    logic                     last;

    assign pop       = (state_reg == ST_IDLE) && q_stat.valid;
    assign q_cmd.pop = pop;
    assign q_cmd.valid = (state_reg == ST_WALK);

    always_comb
    begin
        major = head.xmajor ? head.adx : head.ady;
        minor = head.xmajor ? head.ady : head.adx;

        ox   = OFS_W'(x_reg) - OFS_W'(cx_reg);
        oy   = OFS_W'(y_reg) - OFS_W'(cy_reg);
        aox  = ox[OFS_W-1] ? OFS_W'(-ox) : OFS_W'(ox);
        aoy  = oy[OFS_W-1] ? OFS_W'(-oy) : OFS_W'(oy);
        px   = $signed({{(PEN_W-HALF_W){1'b0}}, hx_reg}) - $signed({1'b0, aox});
        py   = $signed({{(PEN_W-HALF_W){1'b0}}, hy_reg}) - $signed({1'b0, aoy});
        px_s = ox[OFS_W-1] ? -px : px;
        py_s = oy[OFS_W-1] ? -py : py;
        hit    = !px[PEN_W-1] && (px != '0) && !py[PEN_W-1] && (py != '0);
        pick_x = (px < py);

        err_a    = err_reg + inc_a_reg;
        err_b    = err_reg + inc_b_reg;
        minor_go = (err_a > 0);
        x_step   = x_reg + $signed({{(PT_W-1){sx_neg_reg}}, 1'b1});
        y_step   = y_reg + $signed({{(PT_W-1){sy_neg_reg}}, 1'b1});
        last     = hit || (cnt_reg == '0);

        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        err_next    = err_reg;
        inc_a_next  = inc_a_reg;
        inc_b_next  = inc_b_reg;
        cnt_next    = cnt_reg;
        xmaj_next   = xmaj_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        hx_next     = hx_reg;
        hy_next     = hy_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        con_x_next  = con_x_reg;
        con_y_next  = con_y_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next  = ST_WALK;
                    x_next      = PT_W'(head.x);
                    y_next      = PT_W'(head.y);
                    err_next    = -$signed({2'b00, major});
                    inc_a_next  = $signed({1'b0, minor, 1'b0});
                    inc_b_next  = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
                    cnt_next    = head.steps;
                    xmaj_next   = head.xmajor;
                    sx_neg_next = head.sx_neg;
                    sy_neg_next = head.sy_neg;
                    cx_next     = head.cx;
                    cy_next     = head.cy;
                    hx_next     = head.hx;
                    hy_next     = head.hy;
                end
            end
            ST_WALK:
            begin
                // advance one point along the ray
                err_next = minor_go ? err_b : err_a;
                cnt_next = cnt_reg - STEP_W'(1);
                if (xmaj_reg)
                begin
                    x_next = x_step;
                    y_next = minor_go ? y_step : y_reg;
                end
                else
                begin
                    y_next = y_step;
                    x_next = minor_go ? x_step : x_reg;
                end
                if (last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    hit_next   = hit;
                    pen_x_next = '0;
                    pen_y_next = '0;
                    con_x_next = '0;
                    con_y_next = '0;
                    if (hit && pick_x)
                    begin
                        pen_x_next = px_s[PEN_OUT_W-1:0];
                        con_x_next = ox[OFS_W-1]
                                   ? $signed({cx_reg[COORD_W-1], cx_reg}) - $signed({2'b00, hx_reg})
                                   : $signed({cx_reg[COORD_W-1], cx_reg}) + $signed({2'b00, hx_reg});
                        con_y_next = CONTACT_W'(y_reg);
                    end
                    else if (hit)
                    begin
                        pen_y_next = py_s[PEN_OUT_W-1:0];
                        con_x_next = CONTACT_W'(x_reg);
                        con_y_next = oy[OFS_W-1]
                                   ? $signed({cy_reg[COORD_W-1], cy_reg}) - $signed({2'b00, hy_reg})
                                   : $signed({cy_reg[COORD_W-1], cy_reg}) + $signed({2'b00, hy_reg});
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            con_x_reg <= '0;
            con_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            con_x_reg <= con_x_next;
            con_y_reg <= con_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        err_reg    <= err_next;
        inc_a_reg  <= inc_a_next;
        inc_b_reg  <= inc_b_next;
        cnt_reg    <= cnt_next;
        xmaj_reg   <= xmaj_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
    end

    assign done      = done_reg;
    assign is_hit    = hit_reg;
    assign pen_x     = pen_x_reg;
    assign pen_y     = pen_y_reg;
    assign contact_x = con_x_reg;
    assign contact_y = con_y_reg;

endmodule

// ===== design/line_walk_box_hit.sv =====
// A start transaction is registered into the queue, loaded by the walker, walked point
// by point and its result registered onto the done strobe. Each transaction holds the
// walker through up to steps+1 tested points; it takes the next only after that result.
// A two-entry queue takes new transactions while the walker runs; those wait their turn.
// Reset is asynchronous, active low, and empties the queue and the walker.
// Results are shown for one cycle on the done strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// line_walk_box_hit
// Ray walk against an axis-aligned box: first point strictly inside, with the
// penetration along the shallower axis and the contact point on the box face.
// ----------------------------------------------------------------------------
module line_walk_box_hit #(
    parameter logic [lwbh_pkg::STEP_W-1:0] MAX_STEPS = lwbh_pkg::MAX_STEPS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   ray_x,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   ray_y,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   dir_x,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   dir_y,
    input  logic [lwbh_pkg::STEP_W-1:0]           steps,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   box_cx,
    input  logic signed [lwbh_pkg::COORD_W-1:0]   box_cy,
    input  logic [lwbh_pkg::HALF_W-1:0]           box_hx,
    input  logic [lwbh_pkg::HALF_W-1:0]           box_hy,
    output logic                                  done,
    output logic                                  is_hit,
    output logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_x,
    output logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_y,
    output logic signed [lwbh_pkg::CONTACT_W-1:0] contact_x,
    output logic signed [lwbh_pkg::CONTACT_W-1:0] contact_y
);
    import lwbh_pkg::*;

    item_t   head;
    q_ctrl_t q_stat;
    q_ctrl_t q_cmd;

    lwbh_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ray_x    (ray_x),
        .ray_y    (ray_y),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .steps    (steps),
        .box_cx   (box_cx),
        .box_cy   (box_cy),
        .box_hx   (box_hx),
        .box_hy   (box_hy),
        .head     (head),
        .ctrl_in  (q_cmd),
        .ctrl_out (q_stat)
    );

    lwbh_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .q_cmd     (q_cmd),
        .done      (done),
        .is_hit    (is_hit),
        .pen_x     (pen_x),
        .pen_y     (pen_y),
        .contact_x (contact_x),
        .contact_y (contact_y)
    );

endmodule

// ===== design/lwbh_check.sv =====
// ----------------------------------------------------------------------------
// lwbh_check
// Port-level checks for line_walk_box_hit, bound to the top level.
// ----------------------------------------------------------------------------
module lwbh_check (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic                                  is_hit,
    input logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_x,
    input logic signed [lwbh_pkg::PEN_OUT_W-1:0] pen_y,
    input logic signed [lwbh_pkg::CONTACT_W-1:0] contact_x,
    input logic signed [lwbh_pkg::CONTACT_W-1:0] contact_y
);

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_hit |-> pen_x == 0 && pen_y == 0 && contact_x == 0 && contact_y == 0)
        else $error("miss result carries nonzero fields");

    a_hit_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_hit |-> (pen_x != 0) != (pen_y != 0))
        else $error("hit result must report exactly one penetration axis");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start transaction");

endmodule

bind line_walk_box_hit lwbh_check u_lwbh_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .is_hit    (is_hit),
    .pen_x     (pen_x),
    .pen_y     (pen_y),
    .contact_x (contact_x),
    .contact_y (contact_y)
);

// ===== sim/tb_line_walk_box_hit.sv =====
// ----------------------------------------------------------------------------
// tb_line_walk_box_hit
// Self-checking testbench for the ray walk against box block. Each ray
// transaction is predicted by stepping the ray point by point in the
// testbench. Every done strobe is checked against the oldest predicted hit
// record, under directed cases and random rays, most of them aimed at their boxes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_walk_box_hit;

    import lwbh_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] ray_x;
        logic signed [COORD_W-1:0] ray_y;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic [STEP_W-1:0]         steps;
        logic signed [COORD_W-1:0] box_cx;
        logic signed [COORD_W-1:0] box_cy;
        logic [HALF_W-1:0]         box_hx;
        logic [HALF_W-1:0]         box_hy;
    } ray_t;

    typedef struct {
        logic                        is_hit;
        logic signed [PEN_OUT_W-1:0] pen_x;
        logic signed [PEN_OUT_W-1:0] pen_y;
        logic signed [CONTACT_W-1:0] contact_x;
        logic signed [CONTACT_W-1:0] contact_y;
    } hit_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COORD_W-1:0]   ray_x;
    logic signed [COORD_W-1:0]   ray_y;
    logic signed [COORD_W-1:0]   dir_x;
    logic signed [COORD_W-1:0]   dir_y;
    logic [STEP_W-1:0]           steps;
    logic signed [COORD_W-1:0]   box_cx;
    logic signed [COORD_W-1:0]   box_cy;
    logic [HALF_W-1:0]           box_hx;
    logic [HALF_W-1:0]           box_hy;
    logic                        done;
    logic                        is_hit;
    logic signed [PEN_OUT_W-1:0] pen_x;
    logic signed [PEN_OUT_W-1:0] pen_y;
    logic signed [CONTACT_W-1:0] contact_x;
    logic signed [CONTACT_W-1:0] contact_y;

    hit_t pending_hits[$];
    int   send_idle_pct;
    int   err_count;
    int   n_sent;
    int   n_directed;
    int   n_hits_seen;
    int   n_results;

    line_walk_box_hit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray_x     (ray_x),
        .ray_y     (ray_y),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .steps     (steps),
        .box_cx    (box_cx),
        .box_cy    (box_cy),
        .box_hx    (box_hx),
        .box_hy    (box_hy),
        .done      (done),
        .is_hit    (is_hit),
        .pen_x     (pen_x),
        .pen_y     (pen_y),
        .contact_x (contact_x),
        .contact_y (contact_y)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic hit_t walk_ray_to_hit(ray_t r);
        hit_t    h;
        longint  pt_x;
        longint  pt_y;
        longint  adx;
        longint  ady;
        longint  stx;
        longint  sty;
        longint  err;
        longint  ox;
        longint  oy;
        longint  dpx;
        longint  dpy;
        longint  cx;
        longint  cy;
        longint  hx;
        longint  hy;
        longint  sgn;
        bit      xmajor;
        int      n;
        int      i;
        h = '{default: '0};
        pt_x = longint'(r.ray_x);
        pt_y = longint'(r.ray_y);
        adx  = longint'(r.dir_x);
        ady  = longint'(r.dir_y);
        cx   = longint'(r.box_cx);
        cy   = longint'(r.box_cy);
        hx   = longint'(r.box_hx);
        hy   = longint'(r.box_hy);
        n    = int'(r.steps);
        if (n > int'(MAX_STEPS))
            n = int'(MAX_STEPS);
        stx = 1;
        sty = 1;
        if (adx < 0)
        begin
            adx = -adx;
            stx = -1;
        end
        if (ady < 0)
        begin
            ady = -ady;
            sty = -1;
        end
        xmajor = (ady <= adx);
        err = xmajor ? -adx : -ady;
        for (i = 0; i <= n; i++)
        begin
            ox  = pt_x - cx;
            oy  = pt_y - cy;
            dpx = hx - ((ox < 0) ? -ox : ox);
            dpy = hy - ((oy < 0) ? -oy : oy);
            if (dpx > 0 && dpy > 0)
            begin
                h.is_hit = 1'b1;
                if (dpx < dpy)
                begin
                    sgn = (ox < 0) ? -1 : 1;
                    h.pen_x     = PEN_OUT_W'(dpx * sgn);
                    h.contact_x = CONTACT_W'(cx + hx * sgn);
                    h.contact_y = CONTACT_W'(pt_y);
                end
                else
                begin
                    sgn = (oy < 0) ? -1 : 1;
                    h.pen_y     = PEN_OUT_W'(dpy * sgn);
                    h.contact_x = CONTACT_W'(pt_x);
                    h.contact_y = CONTACT_W'(cy + hy * sgn);
                end
                return h;
            end
            if (xmajor)
            begin
                err += 2 * ady;
                if (err > 0)
                begin
                    pt_y += sty;
                    err  -= 2 * adx;
                end
                pt_x += stx;
            end
            else
            begin
                err += 2 * adx;
                if (err > 0)
                begin
                    pt_x += stx;
                    err  -= 2 * ady;
                end
                pt_y += sty;
            end
        end
        return h;
    endfunction

    function automatic ray_t mk_ray(int x, int y, int dx, int dy, int n,
                                    int cx, int cy, int hx, int hy);
        ray_t r;
        r.ray_x  = COORD_W'(x);
        r.ray_y  = COORD_W'(y);
        r.dir_x  = COORD_W'(dx);
        r.dir_y  = COORD_W'(dy);
        r.steps  = STEP_W'(n);
        r.box_cx = COORD_W'(cx);
        r.box_cy = COORD_W'(cy);
        r.box_hx = HALF_W'(hx);
        r.box_hy = HALF_W'(hy);
        return r;
    endfunction

    function automatic ray_t noise_ray();
        return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic int pick_dir();
        case ($urandom_range(5))
            0: return $urandom;
            1: return ($urandom_range(1)) ? 32767 : -32767;
            2: return ($urandom_range(1)) ? -32768 : 0;
            default: return $urandom_range(16) - 8;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] clip_coord(longint v);
        if (v > 32767)
            return COORD_W'(32767);
        if (v < -32768)
            return COORD_W'(-32768);
        return COORD_W'(v);
    endfunction

    // place the box near a point on the ray's line, up to four steps past the walk, so most rays hit
    function automatic ray_t aimed_ray();
        ray_t   r;
        longint adx;
        longint ady;
        longint major;
        longint k;
        longint tx;
        longint ty;
        r = noise_ray();
        r.dir_x = COORD_W'(pick_dir());
        r.dir_y = COORD_W'(pick_dir());
        r.steps = ($urandom_range(19) == 0) ? STEP_W'($urandom_range(1023))
                                            : STEP_W'($urandom_range(40));
        if ($urandom_range(7) == 0)
        begin
            r.ray_x = ($urandom_range(1)) ? COORD_W'(32767) : COORD_W'(-32768);
            r.ray_y = ($urandom_range(1)) ? COORD_W'(32767) : COORD_W'(-32768);
        end
        adx   = (r.dir_x < 0) ? -longint'(r.dir_x) : longint'(r.dir_x);
        ady   = (r.dir_y < 0) ? -longint'(r.dir_y) : longint'(r.dir_y);
        major = (adx >= ady) ? adx : ady;
        k     = $urandom_range(int'(r.steps) + 4);
        if (major == 0)
        begin
            tx = longint'(r.ray_x) + k;
            ty = longint'(r.ray_y);
        end
        else
        begin
            tx = longint'(r.ray_x) + k * longint'(r.dir_x) / major;
            ty = longint'(r.ray_y) + k * longint'(r.dir_y) / major;
        end
        r.box_cx = clip_coord(tx + $urandom_range(6) - 3);
        r.box_cy = clip_coord(ty + $urandom_range(6) - 3);
        r.box_hx = ($urandom_range(9) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(12));
        r.box_hy = ($urandom_range(9) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(12));
        return r;
    endfunction

    task automatic drive_fields(ray_t r);
        ray_x  <= r.ray_x;
        ray_y  <= r.ray_y;
        dir_x  <= r.dir_x;
        dir_y  <= r.dir_y;
        steps  <= r.steps;
        box_cx <= r.box_cx;
        box_cy <= r.box_cy;
        box_hx <= r.box_hx;
        box_hy <= r.box_hy;
    endtask

    task automatic send_ray(ray_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            drive_fields(noise_ray());
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        drive_fields(r);
        do
            @(posedge clk);
        while (busy);
        pending_hits.push_back(walk_ray_to_hit(r));
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (is_hit)
                n_hits_seen++;
            if (pending_hits.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
            end
            else
            begin
                want = pending_hits.pop_front();
                if (is_hit !== want.is_hit)
                    report_mismatch($sformatf("is_hit %0b, want %0b", is_hit, want.is_hit));
                if (pen_x !== want.pen_x)
                    report_mismatch($sformatf("pen_x %0d, want %0d", pen_x, want.pen_x));
                if (pen_y !== want.pen_y)
                    report_mismatch($sformatf("pen_y %0d, want %0d", pen_y, want.pen_y));
                if (contact_x !== want.contact_x)
                    report_mismatch($sformatf("contact_x %0d, want %0d",
                                              contact_x, want.contact_x));
                if (contact_y !== want.contact_y)
                    report_mismatch($sformatf("contact_y %0d, want %0d",
                                              contact_y, want.contact_y));
            end
        end
    end

    task automatic test_hit_geometry();
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 1, 1));
        send_ray(mk_ray(3, 0, 0, 0, 0, 0, 0, 5, 10));
        send_ray(mk_ray(-3, 0, 0, 0, 0, 0, 0, 5, 10));
        send_ray(mk_ray(0, -4, 0, 0, 0, 0, 0, 10, 6));
        send_ray(mk_ray(0, 4, 0, 0, 0, 0, 0, 10, 6));
        send_ray(mk_ray(2, -2, 0, 0, 0, 0, 0, 5, 5));
        send_ray(mk_ray(10, 10, 1, 0, 30, 0, 0, 32767, 0));
    endtask

    task automatic test_walk_directions();
        send_ray(mk_ray(0, 0, 0, 0, 20, 15, 0, 3, 3));
        send_ray(mk_ray(0, 0, 5, 5, 30, 20, 20, 2, 4));
        send_ray(mk_ray(0, 0, -7, 7, 30, -12, 12, 3, 2));
        send_ray(mk_ray(0, 0, 32767, -32767, 40, 25, -25, 2, 2));
        send_ray(mk_ray(0, 0, -32768, 100, 60, -50, 0, 4, 3));
        send_ray(mk_ray(0, 0, 0, -32768, 60, 0, -40, 3, 5));
        send_ray(mk_ray(0, 0, 1, 3, 80, 15, 45, 2, 3));
        send_ray(mk_ray(5, 5, -3, -1, 90, -60, -15, 6, 2));
    endtask

    task automatic test_coordinate_extremes();
        send_ray(mk_ray(32767, 32767, 1, 1, 1023, 32767, 32767, 32767, 32767));
        send_ray(mk_ray(-32768, -32768, -1, -1, 1023, -32768, -32768, 32767, 32767));
        send_ray(mk_ray(32767, 0, 1, 1, 1023, 32767, 500, 2000, 20));
        send_ray(mk_ray(-32768, 0, -1, -1, 1023, -32768, -500, 2000, 20));
        send_ray(mk_ray(-32768, 32767, 32767, -32767, 1023, 0, 0, 0, 32767));
        send_ray(mk_ray(0, 0, 0, 0, 0, -32768, 32767, 32767, 32767));
    endtask

    task automatic test_random_walks(int idle_pct, int count);
        send_idle_pct = idle_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 20)
                send_ray(noise_ray());
            else
                send_ray(aimed_ray());
        end
    endtask

    initial
    begin
        err_count     = 0;
        n_sent        = 0;
        n_hits_seen   = 0;
        n_results     = 0;
        send_idle_pct = 18;
        rst_n  = 1'b0;
        start  = 1'b0;
        ray_x  = '0;
        ray_y  = '0;
        dir_x  = '0;
        dir_y  = '0;
        steps  = '0;
        box_cx = '0;
        box_cy = '0;
        box_hx = '0;
        box_hy = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_hit_geometry();
        test_walk_directions();
        test_coordinate_extremes();
        n_directed = n_sent;
        wait_drained();
        test_random_walks(18, 187);
        wait_drained();
        test_random_walks(53, 187);
        test_random_walks(0, 187);
        wait_drained();
        repeat (1100) @(posedge clk);

        $display("Ran %0d ray transactions: %0d directed, %0d random over three idle profiles.",
                 n_sent, n_directed, n_sent - n_directed);
        $display("Checked %0d results: %0d hits, %0d misses; %0d mismatches.",
                 n_results, n_hits_seen, n_results - n_hits_seen, err_count);
        if (err_count == 0 && pending_hits.size() == 0)
            $display("line_walk_box_hit test passed");
        else
            $display("line_walk_box_hit test failed");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("TIMEOUT: run did not finish, %0d results outstanding", pending_hits.size());
        $display("line_walk_box_hit test failed");
        $finish;
    end

endmodule
